FILE: hdl/mam_pkg.sv
// Package for the matrix add and multiply block.
// Holds field widths, command codes, sequencer states and inter-module structs.
// No dependencies; every other file of the block imports it.
package mam_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DIM_W  = 4;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned SUM_W  = 17;
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 35;

  // Default size of the matrix stores and reset value of the size register.
  localparam int unsigned MAX_DIM_DEF = 8;
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // Command codes of an input transaction.
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A    = 2'd0,
    CMD_WR_B    = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_ISSUE
  } seq_state_e;

  // Element write into the stores.
  typedef struct packed {
    logic                    we_a;
    logic                    we_b;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } wr_req_t;

  // One read of each store, addressed by row and column.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] a_row;
    logic [IDX_W-1:0] a_col;
    logic [IDX_W-1:0] b_row;
    logic [IDX_W-1:0] b_col;
  } rd_req_t;

  // Tag that travels with a read through the arithmetic pipeline.
  typedef struct packed {
    logic             vld;
    logic             first;   // first product of a dot product
    logic             is_sum;  // read of A[r][c] and B[r][c]
    logic             fin;     // closing step of one result element
    logic             last;    // closing element of the burst
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  // Status of the arithmetic pipeline seen by the sequencer.
  typedef struct packed {
    logic busy;      // reads still in flight
    logic out_pend;  // result register holds an untaken result
  } mac_stat_t;

endpackage

FILE: hdl/mam_if.sv
// Channel interfaces of the matrix add and multiply block.
// Input items, result items and the size register write channel.
// Depends on mam_pkg.
interface mam_in_if import mam_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink (input valid, command, row, col, value, output ready);
endinterface

interface mam_out_if import mam_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [SUM_W-1:0]  sum;
  logic signed [PROD_W-1:0] product;
  logic                     last;

  modport source (output valid, out_row, out_col, sum, product, last, input ready);
  modport sink (input valid, out_row, out_col, sum, product, last, output ready);
endinterface

interface mam_cfg_if import mam_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] matrix_dim;

  modport source (output valid, matrix_dim, input ready);
  modport sink (input valid, matrix_dim, output ready);
endinterface

FILE: hdl/mam_store.sv
// Element stores for matrices A and B, one synchronous memory each.
// One write and one registered read per memory and cycle.
// Depends on mam_pkg.
module mam_store import mam_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic                    clk_i,
  input  wr_req_t                 wr_i,
  input  rd_req_t                 rd_i,
  output logic signed [VAL_W-1:0] rd_a_o,
  output logic signed [VAL_W-1:0] rd_b_o
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [VAL_W-1:0] mem_a_q [DEPTH];
  logic signed [VAL_W-1:0] mem_b_q [DEPTH];
  logic signed [VAL_W-1:0] rd_a_q;
  logic signed [VAL_W-1:0] rd_b_q;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ADDR_W-1:0]       rd_addr_a;
  logic [ADDR_W-1:0]       rd_addr_b;
  logic                    wr_in_range;

  // Row-major address of an element.
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(MAX_DIM);
    return base + ADDR_W'(col);
  endfunction

  // Writes outside the stored square are dropped.
  assign wr_in_range = ({1'b0, wr_i.row} < DIM_W'(MAX_DIM)) &&
                       ({1'b0, wr_i.col} < DIM_W'(MAX_DIM));
  assign wr_addr   = elem_addr(wr_i.row, wr_i.col);
  assign rd_addr_a = elem_addr(rd_i.a_row, rd_i.a_col);
  assign rd_addr_b = elem_addr(rd_i.b_row, rd_i.b_col);

  // Matrix A memory.
  always_ff @(posedge clk_i) begin
    if (wr_i.we_a && wr_in_range) begin
      mem_a_q[wr_addr] <= wr_i.value;
    end
    if (rd_i.en) begin
      rd_a_q <= mem_a_q[rd_addr_a];
    end
  end

  // Matrix B memory.
  always_ff @(posedge clk_i) begin
    if (wr_i.we_b && wr_in_range) begin
      mem_b_q[wr_addr] <= wr_i.value;
    end
    if (rd_i.en) begin
      rd_b_q <= mem_b_q[rd_addr_b];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

FILE: hdl/mam_seq.sv
// Command sequencer: takes input transactions, issues element writes and,
// for a compute command, walks the result elements and issues store reads.
// Depends on mam_pkg and mam_if.
module mam_seq import mam_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mam_in_if.sink           in_i,
  input  logic [DIM_W-1:0] dim_i,
  input  mac_stat_t        stat_i,
  output wr_req_t          wr_o,
  output rd_req_t          rd_o,
  output tag_t             tag_o
);

  seq_state_e       state_q, state_d;
  logic [IDX_W-1:0] r_q, c_q;
  logic [DIM_W-1:0] k_q, n_q;
  logic [DIM_W-1:0] dim_act;
  logic [IDX_W-1:0] n_m1;
  logic [IDX_W-1:0] k_idx;
  logic             accept;
  logic             start;
  logic             sum_step;
  logic             last_elem;

  // Size in use, clamped to 1..MAX_DIM.
  always_comb begin
    if (dim_i == '0) begin
      dim_act = DIM_W'(1);
    end else if (dim_i > DIM_W'(MAX_DIM)) begin
      dim_act = DIM_W'(MAX_DIM);
    end else begin
      dim_act = dim_i;
    end
  end

  // The input is ready exactly in the idle state.
  assign accept    = in_i.valid && (state_q == ST_IDLE);
  assign start     = accept && (in_i.command == CMD_COMPUTE);
  assign n_m1      = IDX_W'(n_q - DIM_W'(1));
  assign k_idx     = k_q[IDX_W-1:0];
  assign sum_step  = (k_q == n_q);
  assign last_elem = (r_q == n_m1) && (c_q == n_m1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!stat_i.busy && !stat_i.out_pend) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (sum_step) begin
          state_d = last_elem ? ST_IDLE : ST_WAIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: input handshake, element writes, reads and their tags.
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);

    wr_o.we_a  = accept && (in_i.command == CMD_WR_A);
    wr_o.we_b  = accept && (in_i.command == CMD_WR_B);
    wr_o.row   = in_i.row;
    wr_o.col   = in_i.col;
    wr_o.value = in_i.value;

    rd_o.en    = (state_q == ST_ISSUE);
    rd_o.a_row = r_q;
    rd_o.a_col = sum_step ? c_q : k_idx;
    rd_o.b_row = sum_step ? r_q : k_idx;
    rd_o.b_col = c_q;

    tag_o.vld    = (state_q == ST_ISSUE);
    tag_o.first  = (k_q == '0);
    tag_o.is_sum = sum_step;
    tag_o.fin    = sum_step;
    tag_o.last   = last_elem;
    tag_o.row    = r_q;
    tag_o.col    = c_q;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Element and dot product counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      c_q <= '0;
      k_q <= '0;
      n_q <= DIM_W'(1);
    end else if (state_q == ST_IDLE) begin
      if (start) begin
        r_q <= '0;
        c_q <= '0;
        k_q <= '0;
        n_q <= dim_act;
      end
    end else if (state_q == ST_ISSUE) begin
      if (sum_step) begin
        k_q <= '0;
        if (c_q == n_m1) begin
          c_q <= '0;
          r_q <= r_q + IDX_W'(1);
        end else begin
          c_q <= c_q + IDX_W'(1);
        end
      end else begin
        k_q <= k_q + DIM_W'(1);
      end
    end
  end

endmodule

FILE: hdl/mam_mac.sv
// Arithmetic pipeline: multiply, accumulate the dot product, form the sum
// and hold the finished result in the output register.
// Depends on mam_pkg and mam_if.
module mam_mac import mam_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tag_t                    tag_i,
  input  logic signed [VAL_W-1:0] rd_a_i,
  input  logic signed [VAL_W-1:0] rd_b_i,
  mam_out_if.source               out_o,
  output mac_stat_t               stat_o
);

  tag_t                     tag1_q, tag2_q;
  logic signed [MUL_W-1:0]  mul_d, mul_q;
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic signed [PROD_W-1:0] acc_q;
  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic signed [SUM_W-1:0]  out_sum_q;
  logic signed [PROD_W-1:0] out_prod_q;
  logic                     out_last_q;

  assign mul_d = MUL_W'(rd_a_i) * MUL_W'(rd_b_i);
  assign sum_d = SUM_W'(rd_a_i) + SUM_W'(rd_b_i);

  // Tags follow the read data down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  // Product or element sum of the read pair.
  always_ff @(posedge clk_i) begin
    if (tag1_q.vld) begin
      if (tag1_q.is_sum) begin
        sum_q <= sum_d;
      end else begin
        mul_q <= mul_d;
      end
    end
  end

  // Dot product accumulator, restarted by the first product.
  always_ff @(posedge clk_i) begin
    if (tag2_q.vld && !tag2_q.is_sum) begin
      if (tag2_q.first) begin
        acc_q <= PROD_W'(mul_q);
      end else begin
        acc_q <= acc_q + PROD_W'(mul_q);
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tag2_q.vld && tag2_q.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (tag2_q.vld && tag2_q.fin) begin
      out_row_q  <= tag2_q.row;
      out_col_q  <= tag2_q.col;
      out_sum_q  <= sum_q;
      out_prod_q <= acc_q;
      out_last_q <= tag2_q.last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.out_row = out_row_q;
  assign out_o.out_col = out_col_q;
  assign out_o.sum     = out_sum_q;
  assign out_o.product = out_prod_q;
  assign out_o.last    = out_last_q;

  assign stat_o.busy     = tag1_q.vld || tag2_q.vld;
  assign stat_o.out_pend = out_valid_q;

endmodule

FILE: hdl/matrix_add_and_multiply.sv
// Top level of the square matrix add and multiply block.
// Instantiates the sequencer, the element stores and the arithmetic pipeline.
// Depends on mam_pkg, mam_if, mam_store, mam_seq and mam_mac.

// Write commands store one element of A or B, so loads stream at one
// transaction per clock while the block is idle. A compute command
// emits n*n results in row-major order, n being the size register
// clamped to 1..MAX_DIM. Each result element costs n+1 reads of the two
// stores (n products plus the A+B pair), which then pass the multiply and
// accumulate pipeline; the next element is issued only once the pipeline
// has drained and the result register has been taken by the sink. New
// input is taken once the last element has been issued, while its
// results are still on their way out. The size register may be written at
// any time the block is idle; it is sampled when a compute command arrives.
module matrix_add_and_multiply import mam_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mam_cfg_if.sink    cfg_i,
  mam_in_if.sink     in_i,
  mam_out_if.source  out_o
);

  logic [DIM_W-1:0]        dim_q;
  wr_req_t                 wr_req;
  rd_req_t                 rd_req;
  tag_t                    tag;
  mac_stat_t               mac_stat;
  logic signed [VAL_W-1:0] rd_a;
  logic signed [VAL_W-1:0] rd_b;

  // Size register; always ready for a write.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RESET;
    end else if (cfg_i.valid) begin
      dim_q <= cfg_i.matrix_dim;
    end
  end

  mam_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .dim_i  (dim_q),
    .stat_i (mac_stat),
    .wr_o   (wr_req),
    .rd_o   (rd_req),
    .tag_o  (tag)
  );

  mam_store #(
    .MAX_DIM (MAX_DIM)
  ) u_store (
    .clk_i  (clk_i),
    .wr_i   (wr_req),
    .rd_i   (rd_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  mam_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag),
    .rd_a_i (rd_a),
    .rd_b_i (rd_b),
    .out_o  (out_o),
    .stat_o (mac_stat)
  );

  // No input transaction is taken while store reads are being issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req.en |-> !in_i.ready)
    else $error("input accepted during a compute read sweep");

  // An element sweep only starts with an empty result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req.en |-> !out_o.valid)
    else $error("result register busy during a compute read sweep");

  // A closing read passes tag1_q and tag2_q, then becomes a valid result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_req.en && tag.fin) |-> ##3 out_o.valid)
    else $error("result element missing after its closing read");

endmodule
